>>> src/deq_pkg.sv
// shared types and codes for the double-ended queue unit
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_DUMP_START,
        CMD_DUMP_STEP
    } cmd_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_STATUS,
        EMIT_RDATA
    } emit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } state_t;

    typedef struct packed {
        cmd_op_t op;
        emit_t   emit;
        status_t status;
        logic    last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;
    } dp_status_t;

endpackage

>>> src/double_ended_queue_unit.sv
// top level of the double-ended queue unit
//
//  channel   ports                     transaction
//  command   start, op, value          start high while busy low
//  result    strobe, data, status,     strobe high for one cycle
//            last
//
//  push, rejected push, empty pop and empty dump: result shown in the cycle after the command
//  pop: the store read is registered before the result register
//  dump of n entries: one store read and one result per entry
//  reset clears head, count and control; store contents stay unknown until pushed
//  results cannot be held off; a new command may be taken while a result is shown
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic signed [31:0] data,
    output logic [1:0]         status,
    output logic               last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    dp_cmd_t    cmd;
    dp_status_t stat;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (value),
        .stat   (stat),
        .strobe (strobe),
        .data   (data),
        .status (status),
        .last   (last)
    );

endmodule

>>> src/deq_datapath.sv
// ring store, head and count registers, dump walker and result registers
module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] value,
    output dp_status_t         stat,
    output logic               strobe,
    output logic signed [31:0] data,
    output logic [1:0]         status,
    output logic               last
);

    logic [31:0]      mem [CAPACITY];
    logic [31:0]      rdata_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] walk_ptr_reg, walk_ptr_next;
    logic [CNT_W-1:0] walk_left_reg, walk_left_next;
    logic             strobe_reg;
    logic [31:0]      data_reg;
    logic [1:0]       status_reg;
    logic             last_reg;

    logic [IDX_W-1:0] head_dec, head_inc, back_slot, tail_slot, walk_inc;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic             wr_en, rd_en;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(CAPACITY))
            s = s - (CNT_W+1)'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

    assign head_dec  = ring_add(head_reg, CNT_W'(CAPACITY - 1));
    assign head_inc  = ring_add(head_reg, CNT_W'(1));
    assign back_slot = ring_add(head_reg, count_reg);
    assign tail_slot = ring_add(head_reg, count_reg - CNT_W'(1));
    assign walk_inc  = ring_add(walk_ptr_reg, CNT_W'(1));

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        walk_ptr_next  = walk_ptr_reg;
        walk_left_next = walk_left_reg;
        wr_en          = 1'b0;
        wr_addr        = head_dec;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        unique case (cmd.op)
            CMD_PUSH_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_dec;
                head_next  = head_dec;
                count_next = count_reg + CNT_W'(1);
            end
            CMD_PUSH_BACK:
            begin
                wr_en      = 1'b1;
                wr_addr    = back_slot;
                count_next = count_reg + CNT_W'(1);
            end
            CMD_POP_FRONT:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
            end
            CMD_POP_BACK:
            begin
                rd_en      = 1'b1;
                rd_addr    = tail_slot;
                count_next = count_reg - CNT_W'(1);
            end
            CMD_DUMP_START:
            begin
                rd_en          = 1'b1;
                rd_addr        = head_reg;
                walk_ptr_next  = head_reg;
                walk_left_next = count_reg;
            end
            CMD_DUMP_STEP:
            begin
                rd_en          = 1'b1;
                rd_addr        = walk_inc;
                walk_ptr_next  = walk_inc;
                walk_left_next = walk_left_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            walk_ptr_reg  <= '0;
            walk_left_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            walk_ptr_reg  <= walk_ptr_next;
            walk_left_reg <= walk_left_next;
            strobe_reg    <= (cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            data_reg   <= (cmd.emit == EMIT_RDATA) ? rdata_reg : 32'd0;
            status_reg <= cmd.status;
            last_reg   <= cmd.last;
        end
    end

    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.walk_last = (walk_left_reg == CNT_W'(1));

    assign strobe = strobe_reg;
    assign data   = data_reg;
    assign status = status_reg;
    assign last   = last_reg;

endmodule

>>> src/deq_ctrl.sv
// controller state machine sequencing pushes, pops and dumps
module deq_ctrl
    import deq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] op,
    input  dp_status_t stat,
    output logic       busy,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_POP_FRONT, OP_POP_BACK:
                            if (!stat.empty)
                                state_next = ST_POP;
                        OP_DUMP:
                            if (!stat.empty)
                                state_next = ST_DUMP;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POP:
                state_next = ST_IDLE;
            ST_DUMP:
                if (stat.walk_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd.op     = CMD_NONE;
        cmd.emit   = EMIT_NONE;
        cmd.status = STAT_OK;
        cmd.last   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            cmd.emit = EMIT_STATUS;
                            if (stat.full)
                                cmd.status = STAT_OVERFLOW;
                            else
                                cmd.op = (op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                : CMD_PUSH_BACK;
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit   = EMIT_STATUS;
                                cmd.status = STAT_UNDERFLOW;
                            end
                            else
                                cmd.op = (op == OP_POP_FRONT) ? CMD_POP_FRONT
                                                               : CMD_POP_BACK;
                        end
                        OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit   = EMIT_STATUS;
                                cmd.status = STAT_EMPTY;
                            end
                            else
                                cmd.op = CMD_DUMP_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
                cmd.emit = EMIT_RDATA;
            ST_DUMP:
            begin
                cmd.emit = EMIT_RDATA;
                cmd.last = stat.walk_last;
                if (!stat.walk_last)
                    cmd.op = CMD_DUMP_STEP;
            end
            default:
            begin
            end
        endcase
    end

endmodule
